// ----- rtl/gram_schmidt_orthogonalize_3d_defines.svh -----
// ---------------------------------------------------------------------------
// gram_schmidt_orthogonalize_3d defines
// assertion macros shared by the rtl files
// ---------------------------------------------------------------------------
`ifndef GRAM_SCHMIDT_ORTHOGONALIZE_3D_DEFINES_SVH
`define GRAM_SCHMIDT_ORTHOGONALIZE_3D_DEFINES_SVH

`ifndef SYNTHESIS
`define GSO3D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSO3D_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GSO3D_ASSERT(lbl, prop, msg)
`define GSO3D_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- rtl/gso3d_pkg.sv -----
// ---------------------------------------------------------------------------
// gso3d_pkg
// widths, control struct and saturation limits of the orthogonalizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gso3d_pkg;

    localparam int CW     = 16;   // input component
    localparam int PW     = 32;   // 16x16 product
    localparam int NCW    = 33;   // cross product component
    localparam int MW     = 32;   // magnitude of projection vector component
    localparam int DW     = 48;   // magnitude of dot product
    localparam int NW     = 64;   // divisor
    localparam int RW     = 32;   // result component
    localparam int Q_BASE = 18;   // quotient bits beyond the up shift
    localparam int X_BASE = 80;   // dividend bits beyond the up shift

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic       valid;
        logic       singular;
        logic       nz;
        logic [2:0] neg;
    } gso3d_ctl_t;

endpackage

// ----- rtl/gso3d_front.sv -----
// ---------------------------------------------------------------------------
// gso3d_front
// cross product, dot products and case select, five register stages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gram_schmidt_orthogonalize_3d_defines.svh"

module gso3d_front
    import gso3d_pkg::*;
#(
    parameter int UP = 8
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [CW-1:0]        a_x,
    input  logic signed [CW-1:0]        a_y,
    input  logic signed [CW-1:0]        a_z,
    input  logic signed [CW-1:0]        b_x,
    input  logic signed [CW-1:0]        b_y,
    input  logic signed [CW-1:0]        b_z,
    input  logic signed [CW-1:0]        c_x,
    input  logic signed [CW-1:0]        c_y,
    input  logic signed [CW-1:0]        c_z,
    output gso3d_ctl_t                  ctl,
    output logic [2:0][MW-1:0]          mag_p,
    output logic [DW-1:0]               mag_d,
    output logic [NW-1:0]               div_n,
    output logic [2:0][CW+UP-1:0]       base
);

    logic signed [CW-1:0] av [3];
    logic signed [CW-1:0] bv [3];
    logic signed [CW-1:0] cv [3];
    logic signed [CW-1:0] pv [3];
    logic                 a_zero;

    // stage 1
    logic                 v1_reg;
    logic signed [PW-1:0] cr_reg [6];
    logic signed [PW-1:0] pc_reg [3];
    logic signed [PW-1:0] pp_reg [3];
    logic signed [CW-1:0] p1_reg [3];
    logic signed [CW-1:0] c1_reg [3];
    logic                 az1_reg;

    // stage 2
    logic                  v2_reg;
    logic signed [NCW-1:0] n2_reg [3];
    logic signed [33:0]    dp2_reg;
    logic [31:0]           np2_reg;
    logic signed [CW-1:0]  p2_reg [3];
    logic signed [CW-1:0]  c2_reg [3];
    logic                  az2_reg;

    // stage 3
    logic                  v3_reg;
    logic [63:0]           nsq3_reg [3];
    logic signed [48:0]    nc3_reg [3];
    logic signed [NCW-1:0] n3_reg [3];
    logic signed [33:0]    dp3_reg;
    logic [31:0]           np3_reg;
    logic signed [CW-1:0]  p3_reg [3];
    logic signed [CW-1:0]  c3_reg [3];
    logic                  az3_reg;

    // stage 4
    logic                  v4_reg;
    logic [NW-1:0]         nn4_reg;
    logic signed [50:0]    nc4_reg;
    logic signed [NCW-1:0] n4_reg [3];
    logic signed [33:0]    dp4_reg;
    logic [31:0]           np4_reg;
    logic signed [CW-1:0]  p4_reg [3];
    logic signed [CW-1:0]  c4_reg [3];
    logic                  az4_reg;

    // stage 5
    gso3d_ctl_t            ctl_reg;
    gso3d_ctl_t            ctl_next;
    logic [2:0][MW-1:0]    magp_reg;
    logic [2:0][MW-1:0]    magp_next;
    logic [DW-1:0]         magd_reg;
    logic [DW-1:0]         magd_next;
    logic [NW-1:0]         divn_reg;
    logic [NW-1:0]         divn_next;
    logic [2:0][CW+UP-1:0] base_reg;
    logic [2:0][CW+UP-1:0] base_next;

    logic signed [NCW-1:0] n3_mag [3];

    always_comb
    begin
        av[0] = a_x;
        av[1] = a_y;
        av[2] = a_z;
        bv[0] = b_x;
        bv[1] = b_y;
        bv[2] = b_z;
        cv[0] = c_x;
        cv[1] = c_y;
        cv[2] = c_z;
        a_zero = (a_x == '0) && (a_y == '0) && (a_z == '0);
        for (int i = 0; i < 3; i++)
        begin
            pv[i] = a_zero ? bv[i] : av[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n3_mag[i] = (n2_reg[i] < 0) ? -n2_reg[i] : n2_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg[0] <= av[1] * bv[2];
            cr_reg[1] <= av[2] * bv[1];
            cr_reg[2] <= av[2] * bv[0];
            cr_reg[3] <= av[0] * bv[2];
            cr_reg[4] <= av[0] * bv[1];
            cr_reg[5] <= av[1] * bv[0];
            for (int i = 0; i < 3; i++)
            begin
                pc_reg[i] <= pv[i] * cv[i];
                pp_reg[i] <= pv[i] * pv[i];
                p1_reg[i] <= pv[i];
                c1_reg[i] <= cv[i];
            end
            az1_reg <= a_zero;

            n2_reg[0] <= NCW'(cr_reg[0]) - NCW'(cr_reg[1]);
            n2_reg[1] <= NCW'(cr_reg[2]) - NCW'(cr_reg[3]);
            n2_reg[2] <= NCW'(cr_reg[4]) - NCW'(cr_reg[5]);
            dp2_reg   <= 34'(pc_reg[0]) + 34'(pc_reg[1]) + 34'(pc_reg[2]);
            np2_reg   <= $unsigned(pp_reg[0]) + $unsigned(pp_reg[1]) + $unsigned(pp_reg[2]);
            p2_reg    <= p1_reg;
            c2_reg    <= c1_reg;
            az2_reg   <= az1_reg;

            for (int i = 0; i < 3; i++)
            begin
                nsq3_reg[i] <= 64'(n3_mag[i][31:0]) * 64'(n3_mag[i][31:0]);
                nc3_reg[i]  <= 49'(n2_reg[i]) * 49'(c2_reg[i]);
            end
            n3_reg  <= n2_reg;
            dp3_reg <= dp2_reg;
            np3_reg <= np2_reg;
            p3_reg  <= p2_reg;
            c3_reg  <= c2_reg;
            az3_reg <= az2_reg;

            nn4_reg <= nsq3_reg[0] + nsq3_reg[1] + nsq3_reg[2];
            nc4_reg <= 51'(nc3_reg[0]) + 51'(nc3_reg[1]) + 51'(nc3_reg[2]);
            n4_reg  <= n3_reg;
            dp4_reg <= dp3_reg;
            np4_reg <= np3_reg;
            p4_reg  <= p3_reg;
            c4_reg  <= c3_reg;
            az4_reg <= az3_reg;

            magp_reg <= magp_next;
            magd_reg <= magd_next;
            divn_reg <= divn_next;
            base_reg <= base_next;
        end
    end

    // pass-through when a is zero or a and b are parallel
    always_comb
    begin
        logic               pass;
        logic signed [50:0] dsel;
        logic [50:0]        dabs;
        pass = az4_reg || (nn4_reg == '0);
        dsel = pass ? 51'(dp4_reg) : nc4_reg;
        dabs = (dsel < 0) ? $unsigned(-dsel) : $unsigned(dsel);
        ctl_next.valid    = v4_reg;
        ctl_next.singular = pass;
        ctl_next.nz       = pass ? (np4_reg != '0) : 1'b1;
        magd_next         = dabs[DW-1:0];
        divn_next         = pass ? NW'(np4_reg) : nn4_reg;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [NCW-1:0] psel;
            logic [NCW-1:0]        pabs;
            psel = pass ? NCW'(p4_reg[i]) : n4_reg[i];
            pabs = (psel < 0) ? $unsigned(-psel) : $unsigned(psel);
            magp_next[i]   = pabs[MW-1:0];
            ctl_next.neg[i] = (psel < 0) != (dsel < 0);
            base_next[i]   = pass ? {c4_reg[i], UP'(0)} : '0;
        end
    end

    assign ctl   = ctl_reg;
    assign mag_p = magp_reg;
    assign mag_d = magd_reg;
    assign div_n = divn_reg;
    assign base  = base_reg;

    `GSO3D_ASSERT(a_gso3d_regular_nz, (ctl_reg.valid && !ctl_reg.singular) |-> (ctl_reg.nz && divn_reg != '0), "regular item with zero divisor")
    `GSO3D_ASSERT(a_gso3d_nz_match, ctl_reg.valid |-> (ctl_reg.nz == (divn_reg != '0)), "divisor flag out of step")

endmodule

// ----- rtl/gso3d_mul.sv -----
// ---------------------------------------------------------------------------
// gso3d_mul
// dividend build: split 32x48 product over two stages, then up shift
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gso3d_mul
    import gso3d_pkg::*;
#(
    parameter int UP = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  gso3d_ctl_t                    ctl_in,
    input  logic [2:0][MW-1:0]            mag_p,
    input  logic [DW-1:0]                 mag_d,
    input  logic [NW-1:0]                 div_n_in,
    input  logic [2:0][CW+UP-1:0]         base_in,
    output gso3d_ctl_t                    ctl_out,
    output logic [2:0][X_BASE+UP-1:0]     dividend,
    output logic [NW-1:0]                 div_n_out,
    output logic [2:0][CW+UP-1:0]         base_out
);

    localparam int XW = X_BASE + UP;

    gso3d_ctl_t            ctl6_reg;
    gso3d_ctl_t            ctl7_reg;
    logic [63:0]           t0_reg [3];
    logic [47:0]           t1_reg [3];
    logic [NW-1:0]         n6_reg;
    logic [NW-1:0]         n7_reg;
    logic [2:0][CW+UP-1:0] b6_reg;
    logic [2:0][CW+UP-1:0] b7_reg;
    logic [2:0][XW-1:0]    x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end
        else if (en)
        begin
            ctl6_reg <= ctl_in;
            ctl7_reg <= ctl6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t0_reg[i] <= 64'(mag_p[i]) * 64'(mag_d[31:0]);
                t1_reg[i] <= 48'(mag_p[i]) * 48'(mag_d[DW-1:32]);
                x_reg[i]  <= (XW'(t0_reg[i]) + (XW'(t1_reg[i]) << 32)) << UP;
            end
            n6_reg <= div_n_in;
            n7_reg <= n6_reg;
            b6_reg <= base_in;
            b7_reg <= b6_reg;
        end
    end

    assign ctl_out   = ctl7_reg;
    assign dividend  = x_reg;
    assign div_n_out = n7_reg;
    assign base_out  = b7_reg;

endmodule

// ----- rtl/gso3d_div.sv -----
// ---------------------------------------------------------------------------
// gso3d_div
// three-lane restoring divider, one quotient bit per register stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gram_schmidt_orthogonalize_3d_defines.svh"

module gso3d_div
    import gso3d_pkg::*;
#(
    parameter int UP = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  gso3d_ctl_t                    ctl_in,
    input  logic [2:0][X_BASE+UP-1:0]     dividend,
    input  logic [NW-1:0]                 div_n,
    input  logic [2:0][CW+UP-1:0]         base_in,
    output gso3d_ctl_t                    ctl_out,
    output logic [2:0][Q_BASE+UP-1:0]     quot,
    output logic [2:0][CW+UP-1:0]         base_out
);

    localparam int QW = Q_BASE + UP;
    localparam int XW = X_BASE + UP;

    logic [NW:0]           rem_reg  [QW][3];
    logic [NW:0]           rem_next [QW][3];
    logic [QW-1:0]         lq_reg   [QW][3];
    logic [QW-1:0]         lq_next  [QW][3];
    logic [NW-1:0]         n_reg    [QW];
    gso3d_ctl_t            ctl_reg  [QW];
    logic [2:0][CW+UP-1:0] base_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [NW:0]   rem_in;
            logic [QW-1:0] lq_in;
            logic [NW-1:0] n_in;
            logic [NW:0]   sh;
            logic          ge;
            if (k == 0)
            begin : g_first
                assign rem_in = (NW+1)'(dividend[l][XW-1:QW]);
                assign lq_in  = dividend[l][QW-1:0];
                assign n_in   = div_n;
            end
            else
            begin : g_more
                assign rem_in = rem_reg[k-1][l];
                assign lq_in  = lq_reg[k-1][l];
                assign n_in   = n_reg[k-1];
            end
            assign sh            = {rem_in[NW-1:0], lq_in[QW-1]};
            assign ge            = sh >= {1'b0, n_in};
            assign rem_next[k][l] = ge ? (sh - {1'b0, n_in}) : sh;
            assign lq_next[k][l]  = {lq_in[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                ctl_reg[k] <= (k == 0) ? ctl_in : ctl_reg[k == 0 ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                lq_reg[k]   <= lq_next[k];
                n_reg[k]    <= (k == 0) ? div_n : n_reg[k == 0 ? 0 : k-1];
                base_reg[k] <= (k == 0) ? base_in : base_reg[k == 0 ? 0 : k-1];
            end
        end
    end

    assign ctl_out  = ctl_reg[QW-1];
    assign base_out = base_reg[QW-1];
    for (genvar l = 0; l < 3; l++)
    begin : g_out
        assign quot[l] = lq_reg[QW-1][l];
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_chk
        `GSO3D_ASSERT(a_gso3d_rem_bound, (ctl_reg[QW-1].valid && ctl_reg[QW-1].nz) |-> (rem_reg[QW-1][l] < {1'b0, n_reg[QW-1]}), "divider remainder not below divisor")
    end

endmodule

// ----- rtl/gram_schmidt_orthogonalize_3d.sv -----
// ---------------------------------------------------------------------------
// gram_schmidt_orthogonalize_3d
// part of c normal to a and b (to a or b if singular), signed q16.16, saturated
// ---------------------------------------------------------------------------
//   channel  handshake                payload
//   item     item_valid / item_stall  a_x..c_z, 16 bit signed
//   result   res_valid / res_stall    res_x res_y res_z 32 bit, singular
//
// one item per cycle while no result is held; the divider resolves one
// quotient bit per stage in each of three lanes
// reset clears the valid bits and control words only, no clearing pass
// a held result stalls the whole pipeline; item_stall follows res_stall then
`timescale 1ns / 1ps
`include "gram_schmidt_orthogonalize_3d_defines.svh"

module gram_schmidt_orthogonalize_3d
    import gso3d_pkg::*;
#(
    parameter int IN_FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic signed [CW-1:0] a_x,
    input  logic signed [CW-1:0] a_y,
    input  logic signed [CW-1:0] a_z,
    input  logic signed [CW-1:0] b_x,
    input  logic signed [CW-1:0] b_y,
    input  logic signed [CW-1:0] b_z,
    input  logic signed [CW-1:0] c_x,
    input  logic signed [CW-1:0] c_y,
    input  logic signed [CW-1:0] c_z,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic signed [RW-1:0] res_x,
    output logic signed [RW-1:0] res_y,
    output logic signed [RW-1:0] res_z,
    output logic                 singular
);

    localparam int UP = 16 - IN_FRAC_BITS;
    localparam int QW = Q_BASE + UP;
    localparam int XW = X_BASE + UP;
    localparam int BW = CW + UP;
    localparam int SW = QW + 2;

    logic en;

    gso3d_ctl_t            f_ctl;
    logic [2:0][MW-1:0]    f_magp;
    logic [DW-1:0]         f_magd;
    logic [NW-1:0]         f_n;
    logic [2:0][BW-1:0]    f_base;

    gso3d_ctl_t            m_ctl;
    logic [2:0][XW-1:0]    m_x;
    logic [NW-1:0]         m_n;
    logic [2:0][BW-1:0]    m_base;

    gso3d_ctl_t            d_ctl;
    logic [2:0][QW-1:0]    d_q;
    logic [2:0][BW-1:0]    d_base;

    logic                  valid_reg;
    logic                  sing_reg;
    logic signed [RW-1:0]  res_reg  [3];
    logic signed [RW-1:0]  res_next [3];

    assign en         = !(valid_reg && res_stall);
    assign item_stall = !en;

    gso3d_front #(.UP(UP)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (item_valid),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_z      (a_z),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_z      (b_z),
        .c_x      (c_x),
        .c_y      (c_y),
        .c_z      (c_z),
        .ctl      (f_ctl),
        .mag_p    (f_magp),
        .mag_d    (f_magd),
        .div_n    (f_n),
        .base     (f_base)
    );

    gso3d_mul #(.UP(UP)) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (f_ctl),
        .mag_p     (f_magp),
        .mag_d     (f_magd),
        .div_n_in  (f_n),
        .base_in   (f_base),
        .ctl_out   (m_ctl),
        .dividend  (m_x),
        .div_n_out (m_n),
        .base_out  (m_base)
    );

    gso3d_div #(.UP(UP)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (m_ctl),
        .dividend (m_x),
        .div_n    (m_n),
        .base_in  (m_base),
        .ctl_out  (d_ctl),
        .quot     (d_q),
        .base_out (d_base)
    );

    // pass-through subtracts the signed correction, regular case takes it as is
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [SW-1:0] corr;
            logic signed [SW-1:0] sum;
            logic signed [63:0]   wide;
            corr = d_ctl.nz ? $signed(SW'(d_q[i])) : '0;
            sum  = SW'($signed(d_base[i]))
                 + ((d_ctl.neg[i] == d_ctl.singular) ? corr : -corr);
            wide = 64'(sum);
            if (wide > SAT_MAX)
            begin
                res_next[i] = SAT_MAX[RW-1:0];
            end
            else if (wide < SAT_MIN)
            begin
                res_next[i] = SAT_MIN[RW-1:0];
            end
            else
            begin
                res_next[i] = wide[RW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg  <= res_next;
            sing_reg <= d_ctl.singular;
        end
    end

    assign res_valid = valid_reg;
    assign res_x     = res_reg[0];
    assign res_y     = res_reg[1];
    assign res_z     = res_reg[2];
    assign singular  = sing_reg;

    `GSO3D_ASSERT(a_gso3d_stall_cause, item_stall |-> (valid_reg && res_stall), "input stalled without a held result")
    `GSO3D_ASSERT_NEVER(a_gso3d_regular_sat, valid_reg && !sing_reg && IN_FRAC_BITS > 0 && (res_reg[0] == SAT_MIN[RW-1:0]), "regular result hit saturation")

endmodule

// ----- verif/gram_schmidt_orthogonalize_3d_tb.sv -----
// ---------------------------------------------------------------------------
// gram_schmidt_orthogonalize_3d_tb
// checks the 3d orthogonalizer with directed and random vector triples
// against a built-in fixed point predictor, with random idling on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gram_schmidt_orthogonalize_3d_tb;
    import gso3d_pkg::*;

    typedef struct {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
        logic                 sing;
    } normal_part_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic signed [CW-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [CW-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [CW-1:0] c_x = '0, c_y = '0, c_z = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic signed [RW-1:0] res_x, res_y, res_z;
    logic                 singular;

    normal_part_t normal_q[$];
    int  n_fail = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_singular = 0;
    bit  gaps_on = 1'b1;

    gram_schmidt_orthogonalize_3d u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_z      (res_z),
        .singular   (singular)
    );

    always #5 clk = ~clk;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [RW-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[RW-1:0];
    endfunction

    // q minus its projection on p, q unchanged when p is zero
    function automatic void reject(input longint p[3], input longint q[3],
                                   output logic signed [RW-1:0] o[3]);
        longint pq, pp, corr, base;
        pq = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
        pp = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
        for (int i = 0; i < 3; i++)
        begin
            base = q[i] * 256;
            corr = 0;
            if (pp != 0)
            begin
                corr = (mag(p[i]) * mag(pq) * 256) / pp;
                if ((p[i] < 0) != (pq < 0))
                    corr = -corr;
            end
            o[i] = clamp32(base - corr);
        end
    endfunction

    function automatic normal_part_t predict_normal(input longint a[3], input longint b[3],
                                                    input longint c[3]);
        normal_part_t r;
        longint n[3];
        longint nc;
        logic [127:0] nn, num, quo;
        logic signed [RW-1:0] o[3];
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        nn = '0;
        for (int i = 0; i < 3; i++)
            nn += 128'(mag(n[i])) * 128'(mag(n[i]));
        if (a[0] == 0 && a[1] == 0 && a[2] == 0)
        begin
            r.sing = 1'b1;
            reject(b, c, o);
        end
        else if (nn == 0)
        begin
            r.sing = 1'b1;
            reject(a, c, o);
        end
        else
        begin
            r.sing = 1'b0;
            nc = n[0] * c[0] + n[1] * c[1] + n[2] * c[2];
            for (int i = 0; i < 3; i++)
            begin
                num = (128'(mag(n[i])) * 128'(mag(nc))) << 8;
                quo = num / nn;
                if ((n[i] < 0) != (nc < 0))
                    o[i] = (quo >= 128'h80000000) ? 32'sh80000000 : -quo[RW-1:0];
                else
                    o[i] = (quo > 128'h7fffffff) ? 32'sh7fffffff : quo[RW-1:0];
            end
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
        return r;
    endfunction

    task automatic send_item(input logic signed [CW-1:0] v[9]);
        longint a[3], b[3], c[3];
        for (int i = 0; i < 3; i++)
        begin
            a[i] = v[i];
            b[i] = v[3 + i];
            c[i] = v[6 + i];
        end
        if (gaps_on && $urandom_range(99) < 35)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        item_valid <= 1'b1;
        a_x <= v[0]; a_y <= v[1]; a_z <= v[2];
        b_x <= v[3]; b_y <= v[4]; b_z <= v[5];
        c_x <= v[6]; c_y <= v[7]; c_z <= v[8];
        do
            @(posedge clk);
        while (item_stall);
        normal_q.push_back(predict_normal(a, b, c));
        n_items++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (normal_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        res_stall <= gaps_on && ($urandom_range(99) < 35);

    always @(posedge clk)
    begin
        normal_part_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (normal_q.size() == 0)
            begin
                $error("result with nothing expected");
                n_fail++;
            end
            else
            begin
                e = normal_q.pop_front();
                n_results++;
                if (res_x !== e.x)
                begin
                    $error("res_x expected %0d actual %0d", e.x, res_x);
                    n_fail++;
                end
                if (res_y !== e.y)
                begin
                    $error("res_y expected %0d actual %0d", e.y, res_y);
                    n_fail++;
                end
                if (res_z !== e.z)
                begin
                    $error("res_z expected %0d actual %0d", e.z, res_z);
                    n_fail++;
                end
                if (singular !== e.sing)
                begin
                    $error("singular expected %0d actual %0d", e.sing, singular);
                    n_fail++;
                end
                if (e.sing)
                    n_singular++;
            end
        end
    end

    function automatic logic signed [CW-1:0] pick_comp();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            3: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [CW-1:0] v[9];
        v = '{default: '0};
        send_item(v);
        v = '{default: 16'sh7fff};
        send_item(v);
        v = '{default: 16'sh8000};
        send_item(v);
        v = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 16'sh0300, 16'sh0400, 16'sh0500};
        send_item(v);
        v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh8000, 16'sh7fff};
        send_item(v);
        // a zero
        v = '{0, 0, 0, 16'sh0100, 16'sh0200, 16'sh8000, 16'sh7fff, 16'sh1234, 16'shf00d};
        send_item(v);
        // a and b zero
        v = '{0, 0, 0, 0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh0001};
        send_item(v);
        // b parallel to a, b zero with a nonzero
        v = '{16'sh0010, 16'sh0020, 16'shffd0, 16'sh0030, 16'sh0060, 16'shff70,
              16'sh7fff, 16'sh8000, 16'sh0101};
        send_item(v);
        v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh0000, 16'sh8000};
        send_item(v);
        v = '{16'sh0001, 16'sh7fff, 16'sh8000, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000};
        send_item(v);
        v = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_item(v);
        v = '{16'sh0001, 16'sh0001, 0, 16'sh7fff, 16'sh8000, 16'sh0001,
              16'shffff, 16'shffff, 16'shffff};
        send_item(v);
    endtask

    task automatic test_random(input int count);
        logic signed [CW-1:0] v[9];
        int k;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++)
                v[i] = ($urandom_range(1)) ? 16'($urandom) : pick_comp();
            case ($urandom_range(9))
                0: v[0:2] = '{0, 0, 0};
                1:
                begin
                    v[0:2] = '{0, 0, 0};
                    v[3:5] = '{0, 0, 0};
                end
                2, 3:
                begin
                    k = $signed($urandom_range(0, 16)) - 8;
                    for (int i = 0; i < 3; i++)
                    begin
                        v[i] = 16'($signed($urandom_range(0, 4000)) - 2000);
                        v[3 + i] = 16'(int'(v[i]) * k);
                    end
                end
                default: ;
            endcase
            send_item(v);
        end
    endtask

    task automatic test_pause_until_drained();
        test_random(40);
        wait_drained();
        test_random(40);
    endtask

    task automatic test_no_idling();
        gaps_on = 1'b0;
        test_random(400);
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_pause_until_drained();
        test_no_idling();
        test_random(760);
        wait_drained();
        repeat (40) @(posedge clk);
        $display("%0d vector triples sent, %0d results checked, %0d with singular set",
                 n_items, n_results, n_singular);
        if (n_fail == 0)
            $display("** gram_schmidt_orthogonalize_3d: PASSED **");
        else
            $display("** gram_schmidt_orthogonalize_3d: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** gram_schmidt_orthogonalize_3d: FAILED **");
        $finish;
    end

endmodule
